// ===== src/ricdf_pkg.sv =====
`default_nettype none

package ricdf_pkg;

    // command codes carried in tuser
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_COUNT  = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef logic [30:0] u_val_t;   // unsigned q1.30
    typedef logic [31:0] coef_t;    // signed q3.28, raw bits

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [31:0] SAT_Q31 = 32'h8000_0000;
    localparam logic signed [63:0] ONE_Q58 = 64'sh0400_0000_0000_0000;
    localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;

    // sideband through the interpolation divider
    typedef struct packed {
        logic        iso;
        logic [31:0] iso_cos;
        logic        zero;
        logic        sat;
        logic        neg;
        logic [30:0] ui;
        logic [30:0] dumag;
        logic [30:0] t;
    } side1_t;

    // sideband through the transform divider
    typedef struct packed {
        logic        iso;
        logic [31:0] iso_cos;
        logic        zero;
        logic        sat;
    } side2_t;

endpackage

`default_nettype wire

// ===== src/ricdf_count_mem.sv =====
`default_nettype none

module ricdf_count_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int CW    = 7
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [CW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [CW-1:0] wr_data,
    output logic               busy
);

    logic [CW-1:0] mem [DEPTH];
    logic [CW-1:0] rd_data_reg;
    logic          busy_reg;
    logic [AW-1:0] clr_idx_reg;

    // clearing sweep after reset, one entry a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_idx_reg == AW'(DEPTH - 1))
                busy_reg <= 1'b0;
            else
                clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            mem[clr_idx_reg] <= '0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

`default_nettype wire

// ===== src/ricdf_point_mem.sv =====
`default_nettype none

module ricdf_point_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire ricdf_pkg::u_val_t  wr_u,
    input  wire ricdf_pkg::coef_t   wr_a,
    input  wire ricdf_pkg::coef_t   wr_b,
    input  wire logic               rd_en,
    input  wire logic [AW-1:0]      rd_addr0,
    input  wire logic [AW-1:0]      rd_addr1,
    output ricdf_pkg::u_val_t       rd_u0,
    output ricdf_pkg::u_val_t       rd_u1,
    output ricdf_pkg::coef_t        rd_a,
    output ricdf_pkg::coef_t        rd_b
);

    import ricdf_pkg::*;

    u_val_t u_mem [DEPTH];
    coef_t  a_mem [DEPTH];
    coef_t  b_mem [DEPTH];

    u_val_t u0_reg, u1_reg;
    coef_t  a_reg, b_reg;

    // u is read at the bin and the next point
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            u_mem[wr_addr] <= wr_u;
            a_mem[wr_addr] <= wr_a;
            b_mem[wr_addr] <= wr_b;
        end
        if (rd_en)
        begin
            u0_reg <= u_mem[rd_addr0];
            u1_reg <= u_mem[rd_addr1];
            a_reg  <= a_mem[rd_addr0];
            b_reg  <= b_mem[rd_addr0];
        end
    end

    assign rd_u0 = u0_reg;
    assign rd_u1 = u1_reg;
    assign rd_a  = a_reg;
    assign rd_b  = b_reg;

endmodule

`default_nettype wire

// ===== src/ricdf_udiv_pipe.sv =====
`default_nettype none

// restoring divider, one quotient bit per stage; needs hi < d
module ricdf_udiv_pipe #(
    parameter int DW = 63,
    parameter int QW = 31,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] in_hi,
    input  wire logic [QW-1:0] in_lo,
    input  wire logic [DW-1:0] in_d,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic      [QW-1:0] out_q,
    output logic      [SW-1:0] out_side
);

    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] lo_reg   [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [DW-1:0] d_reg    [QW];
    logic [SW-1:0] side_reg [QW];
    logic [QW-1:0] valid_reg;

    logic [DW-1:0] src_rem  [QW];
    logic [QW-1:0] src_lo   [QW];
    logic [QW-1:0] src_q    [QW];
    logic [DW-1:0] src_d    [QW];
    logic [SW-1:0] src_side [QW];
    logic [DW:0]   trial    [QW];
    logic          ge       [QW];
    logic [DW-1:0] rem_next [QW];

    always_comb
    begin
        for (int j = 0; j < QW; j++)
        begin
            if (j == 0)
            begin
                src_rem[j]  = in_hi;
                src_lo[j]   = in_lo;
                src_q[j]    = '0;
                src_d[j]    = in_d;
                src_side[j] = in_side;
            end
            else
            begin
                src_rem[j]  = rem_reg[j-1];
                src_lo[j]   = lo_reg[j-1];
                src_q[j]    = q_reg[j-1];
                src_d[j]    = d_reg[j-1];
                src_side[j] = side_reg[j-1];
            end
            trial[j] = {src_rem[j], src_lo[j][QW-1]};
            ge[j]    = trial[j] >= {1'b0, src_d[j]};
            rem_next[j] = ge[j] ? DW'(trial[j] - {1'b0, src_d[j]}) : trial[j][DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < QW; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                lo_reg[j]   <= {src_lo[j][QW-2:0], 1'b0};
                q_reg[j]    <= {src_q[j][QW-2:0], ge[j]};
                d_reg[j]    <= src_d[j];
                side_reg[j] <= src_side[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[QW-2:0], in_valid};
    end

    assign out_valid = valid_reg[QW-1];
    assign out_q     = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

`default_nettype wire

// ===== src/rational_inverse_cdf_sampler.sv =====
`default_nettype none

// channel   dir  payload                                        transfer when
// s_*       in   tuser: cmd; tdata: dist..transf_par (184 b)    s_tvalid & s_tready
// m_*       out  tdata: cos_theta; tuser: was_isotropic         m_tvalid & m_tready
//
// one item a cycle while the pipe is not held; a sample passes through the count and
// point memory reads and the two 31-stage divider pipes
// after reset the count memory is cleared, with s_tready low until the clear is done
// the whole pipe advances together; it holds only while m_tvalid is high and
// m_tready is low, otherwise bubbles and write items keep moving
// point writes land in the same stage that samples read, so order is kept
module rational_inverse_cdf_sampler #(
    parameter int NUM_DISTS  = 1024,
    parameter int MAX_POINTS = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [9:0] dist_index, [15:10] point_index, [46:16] u_value, [78:47] param_a,
    // [110:79] param_b, [117:111] point_count, [149:118] rnd, [180:150] transf_par
    input  wire logic [183:0] s_tdata,
    // [1:0] cmd
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] cos_theta
    output logic      [31:0]  m_tdata,
    // [0] was_isotropic
    output logic              m_tuser
);

    import ricdf_pkg::*;

    localparam int DAW = (NUM_DISTS > 1) ? $clog2(NUM_DISTS) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int IW  = $clog2(MAX_POINTS);
    localparam int PAW = $clog2(NUM_DISTS * MAX_POINTS);
    localparam int PW  = 32 + CW;
    localparam int S1W = $bits(side1_t);
    localparam int S2W = $bits(side2_t);

    // input field unpacking
    logic [9:0]  f_dist;
    logic [5:0]  f_pt;
    logic [6:0]  f_cnt;
    assign f_dist = s_tdata[9:0];
    assign f_pt   = s_tdata[15:10];
    assign f_cnt  = s_tdata[117:111];

    logic adv, acc, clr_busy, f_in_range;
    assign adv        = !m_tvalid || m_tready;
    assign s_tready   = adv && !clr_busy;
    assign acc        = s_tvalid && s_tready;
    assign f_in_range = {3'b0, f_dist} < 13'(NUM_DISTS);

    // count memory, read at transfer, written at transfer
    logic [CW-1:0] cnt_rd, cnt_wr;
    assign cnt_wr = ({2'b0, f_cnt} > 9'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(f_cnt);

    ricdf_count_mem #(.DEPTH(NUM_DISTS), .AW(DAW), .CW(CW)) u_count (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adv),
        .rd_addr (DAW'(f_dist)),
        .rd_data (cnt_rd),
        .wr_en   (acc && s_tuser == CMD_COUNT && f_in_range),
        .wr_addr (DAW'(f_dist)),
        .wr_data (cnt_wr),
        .busy    (clr_busy)
    );

    // stage 1: fields beside the count read
    logic        s1_valid_reg;
    logic [1:0]  s1_cmd_reg;
    logic [9:0]  s1_dist_reg;
    logic [5:0]  s1_pt_reg;
    u_val_t      s1_u_reg;
    coef_t       s1_a_reg, s1_b_reg;
    logic [31:0] s1_rnd_reg;
    logic [30:0] s1_t_reg;
    logic        s1_in_range_reg;

    logic [CW-1:0] s1_n, s1_nm1;
    logic          s1_iso;
    logic [PW-1:0] s1_prod;
    assign s1_n    = s1_in_range_reg ? cnt_rd : '0;
    assign s1_iso  = s1_n < CW'(2);
    assign s1_nm1  = s1_n - 1'b1;
    // bin index in the high bits, fraction in the low word
    assign s1_prod = PW'(s1_rnd_reg) * PW'(s1_nm1);

    // stage 2: point memory access
    logic          s2_valid_reg;
    logic [1:0]    s2_cmd_reg;
    logic [9:0]    s2_dist_reg;
    logic [5:0]    s2_pt_reg;
    u_val_t        s2_u_reg;
    coef_t         s2_a_reg, s2_b_reg;
    logic          s2_in_range_reg;
    logic [IW-1:0] s2_idx_reg;
    logic [29:0]   s2_f30_reg;
    logic          s2_iso_reg;
    logic [31:0]   s2_iso_cos_reg;
    logic [30:0]   s2_t_reg;

    logic [PAW-1:0] s2_base;
    logic [59:0]    s2_fsq;
    logic           pm_wr, pm_rd;
    assign s2_base = PAW'(PAW'(s2_dist_reg) * PAW'(MAX_POINTS)
                     + ((s2_cmd_reg == CMD_WRITE) ? PAW'(s2_pt_reg) : PAW'(s2_idx_reg)));
    assign s2_fsq  = s2_f30_reg * s2_f30_reg;
    assign pm_wr   = adv && s2_valid_reg && s2_cmd_reg == CMD_WRITE && s2_in_range_reg
                     && ({3'b0, s2_pt_reg} < 9'(MAX_POINTS));
    assign pm_rd   = adv && s2_valid_reg && s2_cmd_reg == CMD_SAMPLE && !s2_iso_reg;

    u_val_t pm_u0, pm_u1;
    coef_t  pm_a, pm_b;

    ricdf_point_mem #(.DEPTH(NUM_DISTS * MAX_POINTS), .AW(PAW)) u_points (
        .clk      (clk),
        .wr_en    (pm_wr),
        .wr_addr  (s2_base),
        .wr_u     (s2_u_reg),
        .wr_a     (s2_a_reg),
        .wr_b     (s2_b_reg),
        .rd_en    (pm_rd),
        .rd_addr0 (s2_base),
        .rd_addr1 (PAW'(s2_base + 1'b1)),
        .rd_u0    (pm_u0),
        .rd_u1    (pm_u1),
        .rd_a     (pm_a),
        .rd_b     (pm_b)
    );

    // stage 3: the three products of the rational form
    logic        s3_valid_reg;
    logic [29:0] s3_f30_reg, s3_f2_reg;
    logic        s3_iso_reg;
    logic [31:0] s3_iso_cos_reg;
    logic [30:0] s3_t_reg;

    logic signed [62:0] s3_ma, s3_mb;
    logic signed [33:0] s3_sab;
    logic signed [63:0] s3_mn;
    logic signed [31:0] s3_du;
    assign s3_ma  = $signed(pm_a) * $signed({1'b0, s3_f30_reg});
    assign s3_mb  = $signed(pm_b) * $signed({1'b0, s3_f2_reg});
    assign s3_sab = ONE_Q28 + $signed(pm_a) + $signed(pm_b);
    assign s3_mn  = s3_sab * $signed({1'b0, s3_f30_reg});
    assign s3_du  = $signed({1'b0, pm_u1}) - $signed({1'b0, pm_u0});

    // stage 4: denominator sum
    logic               s4_valid_reg;
    logic signed [62:0] s4_ma_reg, s4_mb_reg;
    logic signed [63:0] s4_mn_reg;
    logic signed [31:0] s4_du_reg;
    u_val_t             s4_ui_reg;
    logic               s4_iso_reg;
    logic [31:0]        s4_iso_cos_reg;
    logic [30:0]        s4_t_reg;

    logic signed [63:0] s4_den;
    logic [31:0]        s4_du_abs;
    assign s4_den    = ONE_Q58 + s4_ma_reg + s4_mb_reg;
    assign s4_du_abs = s4_du_reg[31] ? 32'(-s4_du_reg) : s4_du_reg;

    // stage 5: magnitudes and result sign
    logic               s5_valid_reg;
    logic signed [63:0] s5_num_reg, s5_den_reg;
    logic               s5_du_neg_reg;
    logic [30:0]        s5_dumag_reg;
    u_val_t             s5_ui_reg;
    logic               s5_iso_reg;
    logic [31:0]        s5_iso_cos_reg;
    logic [30:0]        s5_t_reg;

    logic [63:0] s5_nabs, s5_dabs;
    assign s5_nabs = s5_num_reg[63] ? 64'(-s5_num_reg) : s5_num_reg;
    assign s5_dabs = s5_den_reg[63] ? 64'(-s5_den_reg) : s5_den_reg;

    // stage 6: divider entry
    logic        s6_valid_reg;
    logic [62:0] s6_nmag_reg, s6_dmag_reg;
    logic        s6_neg_reg;
    logic [30:0] s6_dumag_reg;
    u_val_t      s6_ui_reg;
    logic        s6_iso_reg;
    logic [31:0] s6_iso_cos_reg;
    logic [30:0] s6_t_reg;

    side1_t d1_in_side, d1_out_side;
    logic   d1_out_valid;
    logic [30:0] d1_q;

    // ratio saturates at 2.0 when num >= 2 den; zero numerator gives zero
    always_comb
    begin
        d1_in_side.iso     = s6_iso_reg;
        d1_in_side.iso_cos = s6_iso_cos_reg;
        d1_in_side.zero    = s6_nmag_reg == '0;
        d1_in_side.sat     = {1'b0, s6_nmag_reg} >= {s6_dmag_reg, 1'b0};
        d1_in_side.neg     = s6_neg_reg;
        d1_in_side.ui      = s6_ui_reg;
        d1_in_side.dumag   = s6_dumag_reg;
        d1_in_side.t       = s6_t_reg;
    end

    ricdf_udiv_pipe #(.DW(63), .QW(31), .SW(S1W)) u_div_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s6_valid_reg),
        .in_hi     ({1'b0, s6_nmag_reg[62:1]}),
        .in_lo     ({s6_nmag_reg[0], 30'b0}),
        .in_d      (s6_dmag_reg),
        .in_side   (d1_in_side),
        .out_valid (d1_out_valid),
        .out_q     (d1_q),
        .out_side  (d1_out_side)
    );

    logic [31:0] d1_rmag;
    assign d1_rmag = d1_out_side.zero ? 32'd0 :
                     d1_out_side.sat  ? SAT_Q31 : {1'b0, d1_q};

    // stage a: ratio registered
    logic        sa_valid_reg;
    logic [31:0] sa_rmag_reg;
    side1_t      sa_side_reg;

    logic [62:0] sa_cprod;
    assign sa_cprod = sa_rmag_reg * sa_side_reg.dumag;

    // stage b: scaled u step
    logic        sb_valid_reg;
    logic [32:0] sb_cmag_reg;
    side1_t      sb_side_reg;

    logic signed [34:0] sb_sum;
    u_val_t             sb_s;
    assign sb_sum = sb_side_reg.neg ?
                    $signed({4'b0, sb_side_reg.ui}) - $signed({2'b0, sb_cmag_reg}) :
                    $signed({4'b0, sb_side_reg.ui}) + $signed({2'b0, sb_cmag_reg});
    // u held in [0, 1]
    assign sb_s = sb_sum[34] ? '0 :
                  (sb_sum > 35'sd1073741824) ? ONE_Q30 : sb_sum[30:0];

    // stage c: interpolated u
    logic        sc_valid_reg;
    u_val_t      sc_s_reg;
    logic [30:0] sc_t_reg;
    logic        sc_iso_reg;
    logic [31:0] sc_iso_cos_reg;

    logic [61:0] sc_ts;
    logic [38:0] sc_d2;
    assign sc_ts = sc_t_reg * sc_s_reg;
    assign sc_d2 = {8'b0, ONE_Q30} - {8'b0, sc_s_reg} + {1'b0, sc_t_reg, 7'b0};

    // stage d: transform numerator and denominator
    logic        sd_valid_reg;
    logic [62:0] sd_n2_reg;
    logic [38:0] sd_d2_reg;
    logic        sd_iso_reg;
    logic [31:0] sd_iso_cos_reg;

    side2_t d2_in_side, d2_out_side;
    logic   d2_out_valid;
    logic [30:0] d2_q;

    // 2tu/(1-u+t) saturates at 2.0, so cos stays at or above -1
    always_comb
    begin
        d2_in_side.iso     = sd_iso_reg;
        d2_in_side.iso_cos = sd_iso_cos_reg;
        d2_in_side.zero    = sd_n2_reg == '0;
        d2_in_side.sat     = sd_n2_reg >= {sd_d2_reg, 24'b0};
    end

    ricdf_udiv_pipe #(.DW(39), .QW(31), .SW(S2W)) u_div_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sd_valid_reg),
        .in_hi     (sd_n2_reg[62:24]),
        .in_lo     ({sd_n2_reg[23:0], 7'b0}),
        .in_d      (sd_d2_reg),
        .in_side   (d2_in_side),
        .out_valid (d2_out_valid),
        .out_q     (d2_q),
        .out_side  (d2_out_side)
    );

    logic [31:0] d2_x, d2_cos;
    assign d2_x   = d2_out_side.zero ? 32'd0 :
                    d2_out_side.sat  ? SAT_Q31 : {1'b0, d2_q};
    assign d2_cos = d2_out_side.iso ? d2_out_side.iso_cos : ({1'b0, ONE_Q30} - d2_x);

    // output register
    logic        out_valid_reg;
    logic [31:0] out_cos_reg;
    logic        out_iso_reg;

    // valid chain; only sample items go on past the point memory stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            sa_valid_reg  <= 1'b0;
            sb_valid_reg  <= 1'b0;
            sc_valid_reg  <= 1'b0;
            sd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= acc;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg && s2_cmd_reg == CMD_SAMPLE;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            sa_valid_reg  <= d1_out_valid;
            sb_valid_reg  <= sa_valid_reg;
            sc_valid_reg  <= sb_valid_reg;
            sd_valid_reg  <= sc_valid_reg;
            out_valid_reg <= d2_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg      <= s_tuser;
            s1_dist_reg     <= f_dist;
            s1_pt_reg       <= f_pt;
            s1_u_reg        <= s_tdata[46:16];
            s1_a_reg        <= s_tdata[78:47];
            s1_b_reg        <= s_tdata[110:79];
            s1_rnd_reg      <= s_tdata[149:118];
            s1_t_reg        <= s_tdata[180:150];
            s1_in_range_reg <= f_in_range;

            s2_cmd_reg      <= s1_cmd_reg;
            s2_dist_reg     <= s1_dist_reg;
            s2_pt_reg       <= s1_pt_reg;
            s2_u_reg        <= s1_u_reg;
            s2_a_reg        <= s1_a_reg;
            s2_b_reg        <= s1_b_reg;
            s2_in_range_reg <= s1_in_range_reg;
            s2_idx_reg      <= s1_prod[32 +: IW];
            s2_f30_reg      <= s1_prod[31:2];
            s2_iso_reg      <= s1_iso;
            s2_iso_cos_reg  <= 32'h4000_0000 - {1'b0, s1_rnd_reg[31:1]};
            s2_t_reg        <= s1_t_reg;

            s3_f30_reg      <= s2_f30_reg;
            s3_f2_reg       <= s2_fsq[59:30];
            s3_iso_reg      <= s2_iso_reg;
            s3_iso_cos_reg  <= s2_iso_cos_reg;
            s3_t_reg        <= s2_t_reg;

            s4_ma_reg       <= s3_ma;
            s4_mb_reg       <= s3_mb;
            s4_mn_reg       <= s3_mn;
            s4_du_reg       <= s3_du;
            s4_ui_reg       <= pm_u0;
            s4_iso_reg      <= s3_iso_reg;
            s4_iso_cos_reg  <= s3_iso_cos_reg;
            s4_t_reg        <= s3_t_reg;

            s5_num_reg      <= s4_mn_reg;
            s5_den_reg      <= s4_den;
            s5_du_neg_reg   <= s4_du_reg[31];
            s5_dumag_reg    <= s4_du_abs[30:0];
            s5_ui_reg       <= s4_ui_reg;
            s5_iso_reg      <= s4_iso_reg;
            s5_iso_cos_reg  <= s4_iso_cos_reg;
            s5_t_reg        <= s4_t_reg;

            s6_nmag_reg     <= s5_nabs[62:0];
            s6_dmag_reg     <= s5_dabs[62:0];
            s6_neg_reg      <= s5_num_reg[63] ^ s5_den_reg[63] ^ s5_du_neg_reg;
            s6_dumag_reg    <= s5_dumag_reg;
            s6_ui_reg       <= s5_ui_reg;
            s6_iso_reg      <= s5_iso_reg;
            s6_iso_cos_reg  <= s5_iso_cos_reg;
            s6_t_reg        <= s5_t_reg;

            sa_rmag_reg     <= d1_rmag;
            sa_side_reg     <= d1_out_side;

            sb_cmag_reg     <= sa_cprod[62:30];
            sb_side_reg     <= sa_side_reg;

            sc_s_reg        <= sb_s;
            sc_t_reg        <= sb_side_reg.t;
            sc_iso_reg      <= sb_side_reg.iso;
            sc_iso_cos_reg  <= sb_side_reg.iso_cos;

            sd_n2_reg       <= {sc_ts, 1'b0};
            sd_d2_reg       <= sc_d2;
            sd_iso_reg      <= sc_iso_reg;
            sd_iso_cos_reg  <= sc_iso_cos_reg;

            out_cos_reg     <= d2_cos;
            out_iso_reg     <= d2_out_side.iso;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_cos_reg;
    assign m_tuser  = out_iso_reg;

    // cosine always within [-1, 1]
    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata) <= 32'sd1073741824
                      && $signed(m_tdata) >= -32'sd1073741824))
        else $error("cos_theta out of range");

    // stored counts never exceed the point capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_in_range_reg) |-> (cnt_rd <= CW'(MAX_POINTS)))
        else $error("point count above capacity");

    // no input transfer while the count memory is being cleared
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !(s_tvalid && s_tready))
        else $error("transfer during count clear");

endmodule

`default_nettype wire
